/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define TPMSV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tpmsv assertion failed");

// clocked check that also holds through reset
`define TPMSV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tpmsv assertion failed");

`endif

/* rtl/tpmsv_pkg.sv */
// ----------------------------------------------------------------------------
// tpmsv_pkg
// Shared widths, limits, types and state encoding for the variance unit.
// ----------------------------------------------------------------------------
package tpmsv_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TOTAL_W     = 26;
    localparam int VAR_W       = 47;
    localparam int ACC_W       = 64;
    localparam int MEAN_W      = 25;
    localparam int DEV_W       = 26;
    localparam int MAG_W       = 25;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int FRAC_SHIFT  = 8;
    localparam int DIV_CNT_W   = $clog2(ACC_W + 1);
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 80;

    localparam logic signed [ACC_W-1:0] TOTAL_MAX = ACC_W'(64'sd33554431);
    localparam logic signed [ACC_W-1:0] TOTAL_MIN = -ACC_W'(64'sd33554432);
    localparam logic [ACC_W-1:0]        VAR_MAX   = ACC_W'(64'h7FFF_FFFF_FFFF);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_PASS,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } sq_ctrl_t;

endpackage

/* rtl/tpmsv_ram.sv */
// ----------------------------------------------------------------------------
// tpmsv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpmsv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tpmsv_divider.sv */
// ----------------------------------------------------------------------------
// tpmsv_divider
// Restoring unsigned divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module tpmsv_divider #(
    parameter int DIVISOR_W = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpmsv_pkg::ACC_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output tpmsv_pkg::div_status_t        status,
    output logic [tpmsv_pkg::ACC_W-1:0]   quotient
);

    localparam int AW = tpmsv_pkg::ACC_W;

    logic [AW-1:0]                       quo_reg, quo_next;
    logic [DIVISOR_W-1:0]                rem_reg, rem_next;
    logic [DIVISOR_W-1:0]                dvs_reg;
    logic [tpmsv_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                                busy_reg, done_reg;
    logic [DIVISOR_W:0]                  rem_shift;
    logic [DIVISOR_W:0]                  rem_diff;
    logic                                ge;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[AW-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        rem_next  = ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        quo_next  = {quo_reg[AW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= tpmsv_pkg::DIV_CNT_W'(AW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tpmsv_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

/* rtl/tpmsv_sqacc.sv */
// ----------------------------------------------------------------------------
// tpmsv_sqacc
// Deviation, square and saturating accumulate pipeline for the second pass.
// ----------------------------------------------------------------------------
module tpmsv_sqacc (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tpmsv_pkg::sq_ctrl_t                    ctrl,
    input  logic signed [tpmsv_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [tpmsv_pkg::MEAN_W-1:0]    mean,
    output logic [tpmsv_pkg::ACC_W-1:0]            acc,
    output logic                                   busy
);

    localparam int DW = tpmsv_pkg::DEV_W;
    localparam int MW = tpmsv_pkg::MAG_W;
    localparam int SW = tpmsv_pkg::SQ_W;
    localparam int AW = tpmsv_pkg::ACC_W;

    logic signed [DW-1:0] dev;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        mag_reg;
    logic [SW-1:0]        sq_reg;
    logic                 v1_reg, v2_reg;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [AW:0]          acc_sum;

    always_comb begin
        dev      = DW'($signed({sample, 8'h00})) - DW'(mean);
        mag      = dev[DW-1] ? MW'(-dev) : MW'(dev);
        acc_sum  = {1'b0, acc_reg} + (AW+1)'(sq_reg);
        acc_next = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag;
        sq_reg  <= SW'(mag_reg * mag_reg);
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;

endmodule

/* rtl/two_pass_mean_sample_variance_unit.sv */
// Samples are taken one per cycle while loading; non-last transactions leave no result.
// After the last sample, n >= 2: the result follows two 64-step passes of the shared
// restoring divider around one buffer read pass at one read per cycle.
// After the last sample, n < 2: the unit skips both passes and goes straight to done.
// Reset clears count, sum, overflow flag and m_tvalid; the sample buffer is not cleared.
// ----------------------------------------------------------------------------
// two_pass_mean_sample_variance_unit
// Buffers Q8.8 samples, then forms the mean and the sample variance in two passes.
// ----------------------------------------------------------------------------
module two_pass_mean_sample_variance_unit #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tpmsv_pkg::TDATA_IN_W-1:0]      s_tdata,  // [15:0] sample
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tpmsv_pkg::TDATA_OUT_W-1:0]     m_tdata,  // [25:0] total, [72:26] variance
    output logic                                  m_tuser   // [0] error
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int SUM_W  = tpmsv_pkg::SAMPLE_W + CNT_W;
    localparam int AW     = tpmsv_pkg::ACC_W;
    localparam int SMW    = tpmsv_pkg::SAMPLE_W;
    localparam int MNW    = tpmsv_pkg::MEAN_W;

    tpmsv_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next, count_after;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        pass_cnt_reg, pass_cnt_next;
    logic                    rd_pending_reg, rd_pending_next;
    logic signed [MNW-1:0]   mean_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [tpmsv_pkg::TOTAL_W-1:0] m_total_reg;
    logic [tpmsv_pkg::VAR_W-1:0]   m_var_reg;
    logic                    m_err_reg;

    logic                    accept, count_inc, out_free, issue, pass_done, few;
    logic                    div_start;
    logic [AW-1:0]           div_dividend;
    logic [CNT_W-1:0]        div_divisor;
    tpmsv_pkg::div_status_t  div_status;
    logic [AW-1:0]           div_quotient;
    tpmsv_pkg::sq_ctrl_t     sq_ctrl;
    logic [AW-1:0]           sq_acc;
    logic                    sq_busy;
    logic [SMW-1:0]          ram_rdata;
    logic signed [SUM_W:0]   sum_wide, sum_abs;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [AW-1:0]    sum_ext;
    logic [tpmsv_pkg::TOTAL_W-1:0] total_sat;
    logic [tpmsv_pkg::VAR_W-1:0]   var_sat;
    logic [MNW-1:0]          q_mean;

    assign accept      = s_tvalid && s_tready;
    assign count_inc   = count_reg < CNT_W'(MAX_ITEMS);
    assign count_after = count_inc ? count_reg + 1'b1 : count_reg;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign issue       = (state_reg == tpmsv_pkg::ST_PASS) && (pass_cnt_reg < count_reg);
    assign pass_done   = !issue && !rd_pending_reg && !sq_busy;
    assign few         = count_reg < CNT_W'(2);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tpmsv_pkg::ST_LOAD: begin
                if (accept && s_tlast) begin
                    state_next = (count_after < CNT_W'(2)) ? tpmsv_pkg::ST_DONE
                                                           : tpmsv_pkg::ST_MEAN_START;
                end
            end
            tpmsv_pkg::ST_MEAN_START: state_next = tpmsv_pkg::ST_MEAN_WAIT;
            tpmsv_pkg::ST_MEAN_WAIT: begin
                if (div_status.done) state_next = tpmsv_pkg::ST_PASS;
            end
            tpmsv_pkg::ST_PASS: begin
                if (pass_done) state_next = tpmsv_pkg::ST_VAR_START;
            end
            tpmsv_pkg::ST_VAR_START: state_next = tpmsv_pkg::ST_VAR_WAIT;
            tpmsv_pkg::ST_VAR_WAIT: begin
                if (div_status.done) state_next = tpmsv_pkg::ST_DONE;
            end
            tpmsv_pkg::ST_DONE: begin
                if (out_free) state_next = tpmsv_pkg::ST_LOAD;
            end
            default: state_next = tpmsv_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        div_start     = 1'b0;
        sq_ctrl.clear = 1'b0;
        sq_ctrl.valid = rd_pending_reg;
        unique case (state_reg)
            tpmsv_pkg::ST_LOAD:       s_tready = 1'b1;
            tpmsv_pkg::ST_MEAN_START: begin
                div_start     = 1'b1;
                sq_ctrl.clear = 1'b1;
            end
            tpmsv_pkg::ST_VAR_START:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        sum_wide     = (SUM_W+1)'(sum_reg);
        sum_abs      = sum_wide[SUM_W] ? -sum_wide : sum_wide;
        sum_mag      = sum_abs[SUM_W-1:0];
        div_dividend = (state_reg == tpmsv_pkg::ST_VAR_START) ? sq_acc
                                                              : AW'({sum_mag, 8'h00});
        div_divisor  = (state_reg == tpmsv_pkg::ST_VAR_START) ? count_reg - 1'b1
                                                              : count_reg;
        q_mean       = div_quotient[MNW-1:0];
        sum_ext      = AW'(sum_reg);
        if (sum_ext > tpmsv_pkg::TOTAL_MAX) begin
            total_sat = tpmsv_pkg::TOTAL_MAX[tpmsv_pkg::TOTAL_W-1:0];
        end else if (sum_ext < tpmsv_pkg::TOTAL_MIN) begin
            total_sat = tpmsv_pkg::TOTAL_MIN[tpmsv_pkg::TOTAL_W-1:0];
        end else begin
            total_sat = sum_ext[tpmsv_pkg::TOTAL_W-1:0];
        end
        if (few) begin
            var_sat = '0;
        end else if (div_quotient > tpmsv_pkg::VAR_MAX) begin
            var_sat = tpmsv_pkg::VAR_MAX[tpmsv_pkg::VAR_W-1:0];
        end else begin
            var_sat = div_quotient[tpmsv_pkg::VAR_W-1:0];
        end
    end

    always_comb begin
        count_next      = count_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        pass_cnt_next   = pass_cnt_reg;
        rd_pending_next = issue;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        if (accept) begin
            if (count_inc) begin
                count_next = count_after;
                sum_next   = sum_reg + SUM_W'($signed(s_tdata[SMW-1:0]));
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (state_reg == tpmsv_pkg::ST_MEAN_START) begin
            pass_cnt_next = '0;
        end
        if (issue) begin
            pass_cnt_next = pass_cnt_reg + 1'b1;
        end
        if (state_reg == tpmsv_pkg::ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            count_next    = '0;
            sum_next      = '0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tpmsv_pkg::ST_LOAD;
            count_reg      <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            pass_cnt_reg   <= '0;
            rd_pending_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            ovf_reg        <= ovf_next;
            pass_cnt_reg   <= pass_cnt_next;
            rd_pending_reg <= rd_pending_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tpmsv_pkg::ST_MEAN_WAIT && div_status.done) begin
            mean_reg <= sum_reg[SUM_W-1] ? -$signed(q_mean) : $signed(q_mean);
        end
        if (state_reg == tpmsv_pkg::ST_DONE && out_free) begin
            m_total_reg <= total_sat;
            m_var_reg   <= var_sat;
            m_err_reg   <= ovf_reg || few;
        end
    end

    tpmsv_ram #(
        .WIDTH (SMW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (accept && count_inc),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_tdata[SMW-1:0]),
        .raddr (pass_cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    tpmsv_divider #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    tpmsv_sqacc u_sqacc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sq_ctrl),
        .sample  ($signed(ram_rdata)),
        .mean    (mean_reg),
        .acc     (sq_acc),
        .busy    (sq_busy)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tpmsv_pkg::TDATA_OUT_W'({m_var_reg, m_total_reg});
    assign m_tuser  = m_err_reg;

endmodule

/* rtl/tpmsv_checker.sv */
// ----------------------------------------------------------------------------
// tpmsv_checker
// Port-level checks for the variance unit, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpmsv_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tpmsv_pkg::TDATA_OUT_W-1:0]  m_tdata
);

    // no result is pending right after reset
    `TPMSV_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)

    // the frame-closing transaction puts the unit into its compute phase
    `TPMSV_ASSERT(a_last_busy, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready)

    // a new result only comes out of the compute phase
    `TPMSV_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready))

    `TPMSV_ASSERT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    `TPMSV_ASSERT(a_data_hold, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))

endmodule

bind two_pass_mean_sample_variance_unit tpmsv_checker u_tpmsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/tb_two_pass_mean_sample_variance_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_pass_mean_sample_variance_unit
// Self-checking bench for the two-pass variance unit. A directed table covers
// single-sample sets, full-scale pairs, a full buffer, buffer overflow, and
// truncation of a negative mean. Random data sets of varied length and value
// mix follow. Every result is checked against a built-in predictor, or for
// typed rows against the table entry. Both stream sides idle at random, and
// the bench adds one long output stall and input pauses for the unit to drain.
// ----------------------------------------------------------------------------
module tb_two_pass_mean_sample_variance_unit;

    localparam int DEPTH          = 1024;
    localparam int SMP_W          = tpmsv_pkg::SAMPLE_W;
    localparam int RAND_ITEMS     = 560;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLDOFF_CYCLES = 1500;
    localparam int HOLDOFF_AT     = 20;
    localparam int NUM_DIR        = 19;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic signed [tpmsv_pkg::TOTAL_W-1:0] total;
        logic [tpmsv_pkg::VAR_W-1:0]          variance;
        logic                                 err_flag;
    } stats_t;

    typedef struct packed {
        logic [SMP_W-1:0] smp;
        logic             last;
        logic [10:0]      reps;
        logic             typed;
        stats_t           want;
    } dir_row_t;

    typedef struct {
        logic [SMP_W-1:0] smp;
        bit               last;
        bit               hold;
        bit               typed;
        stats_t           want;
    } sample_item_t;

    localparam stats_t NO_STATS = '0;

    // row: sample, last, repeat count, typed flag, typed result
    localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
        '{16'h0100, 1'b1, 11'd1,    1'b1, '{26'sd256, 47'd0, 1'b1}},
        '{16'h8000, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h7fff, 1'b1, 11'd1,    1'b1, '{-26'sd1, 47'h7FFF_0000_8000, 1'b0}},
        '{16'h7fff, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h7fff, 1'b1, 11'd1,    1'b1, '{26'sd65534, 47'd0, 1'b0}},
        '{16'h8000, 1'b1, 11'd1,    1'b1, '{-26'sd32768, 47'd0, 1'b1}},
        '{16'h0000, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h0000, 1'b1, 11'd1,    1'b1, '{26'sd0, 47'd0, 1'b0}},
        '{16'h0001, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'hffff, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h5a5a, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'ha5a5, 1'b1, 11'd1,    1'b0, NO_STATS},
        // negative mean truncates toward zero
        '{16'hffff, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h0000, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h0000, 1'b1, 11'd1,    1'b0, NO_STATS},
        // full buffer at negative full scale, last sample dropped
        '{16'h8000, 1'b0, 11'd1024, 1'b0, NO_STATS},
        '{16'h1234, 1'b1, 11'd1,    1'b1, '{26'h200_0000, 47'd0, 1'b1}},
        // overflow flag cleared after a result
        '{16'h0003, 1'b0, 11'd1,    1'b0, NO_STATS},
        '{16'h0003, 1'b1, 11'd1,    1'b1, '{26'sd6, 47'd0, 1'b0}}
    };

    localparam logic [SMP_W-1:0] EXTREMES [5] = '{
        16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001
    };

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [tpmsv_pkg::TDATA_IN_W-1:0]    s_tdata  = '0;
    logic                                s_tlast  = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [tpmsv_pkg::TDATA_OUT_W-1:0]   m_tdata;
    logic                                m_tuser;

    two_pass_mean_sample_variance_unit #(
        .MAX_ITEMS (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic signed [SMP_W-1:0] held_samples [DEPTH];
    int unsigned             held_count    = 0;
    longint                  held_sum      = 0;
    bit                      held_overflow = 1'b0;

    stats_t pending_stats_q [$];
    int     mismatches    = 0;
    int     results_seen  = 0;
    int     sets_seen     = 0;
    int     samples_seen  = 0;
    int     short_sets    = 0;
    int     overflow_sets = 0;
    int     cycle_count   = 0;
    int     rx_wait       = 0;
    bit     tx_burst      = 1'b0;
    bit     rx_burst      = 1'b0;

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 19) == 0) burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Folds one accepted sample into the predictor; returns 1 when a result is due.
    function automatic bit absorb_sample(input logic [SMP_W-1:0] smp, input bit last,
                                         output stats_t res);
        longint      mean;
        longint      dev;
        longint      tot;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] quot;
        res = '0;
        samples_seen++;
        if (held_count < DEPTH) begin
            held_samples[held_count] = smp;
            held_count++;
            held_sum += longint'($signed(smp));
        end else begin
            held_overflow = 1'b1;
        end
        if (!last) return 1'b0;

        acc  = '0;
        quot = '0;
        if (held_count >= 2) begin
            mean = (held_sum * 256) / longint'(held_count);
            for (int i = 0; i < held_count; i++) begin
                dev = longint'(held_samples[i]) * 256 - mean;
                mag = (dev < 0) ? -dev : dev;
                sq  = mag * mag;
                acc = (acc > ~sq) ? '1 : acc + sq;
            end
            quot = acc / (64'(held_count) - 64'd1);
            if (quot > 64'h7FFF_FFFF_FFFF) quot = 64'h7FFF_FFFF_FFFF;
        end
        tot = held_sum;
        if (tot > 33554431) tot = 33554431;
        if (tot < -33554432) tot = -33554432;

        res.total    = tot[tpmsv_pkg::TOTAL_W-1:0];
        res.variance = quot[tpmsv_pkg::VAR_W-1:0];
        res.err_flag = held_overflow || (held_count < 2);

        sets_seen++;
        if (held_count < 2) short_sets++;
        if (held_overflow) overflow_sets++;
        held_count    = 0;
        held_sum      = 0;
        held_overflow = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_stats_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, compare against oldest expectation
    always @(posedge aclk) begin : result_side
        stats_t got;
        stats_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.total    = m_tdata[tpmsv_pkg::TOTAL_W-1:0];
                got.variance = m_tdata[tpmsv_pkg::TOTAL_W +: tpmsv_pkg::VAR_W];
                got.err_flag = m_tuser;
                results_seen++;
                if (pending_stats_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result transaction: total=%0d var=%0d err=%0b",
                                 got.total, got.variance, got.err_flag);
                end else begin
                    want = pending_stats_q.pop_front();
                    if (got.total !== want.total || got.variance !== want.variance ||
                        got.err_flag !== want.err_flag) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Mismatch on result %0d: exp total=%0d var=%0d err=%0b, %s",
                                     results_seen, want.total, want.variance, want.err_flag,
                                     $sformatf("got total=%0d var=%0d err=%0b",
                                               got.total, got.variance, got.err_flag));
                    end
                end
                rx_wait = (results_seen == HOLDOFF_AT) ? HOLDOFF_CYCLES : draw_gap(rx_burst);
                if (rx_wait != 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (rx_wait > 0) rx_wait--;
                if (rx_wait == 0) m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        sample_item_t stim_q [$];
        sample_item_t it;
        stats_t       res;
        logic [SMP_W-1:0] v;
        int  n;
        int  pick;
        int  mode;
        int  gap;
        int  rand_count;
        bit  mid_hold;
        bit  set_hold;
        logic [SMP_W-1:0] base;

        foreach (DIR_TABLE[r]) begin
            for (int k = 0; k < DIR_TABLE[r].reps; k++) begin
                it.smp   = DIR_TABLE[r].smp;
                it.last  = DIR_TABLE[r].last && (k == DIR_TABLE[r].reps - 1);
                it.hold  = 1'b0;
                it.typed = DIR_TABLE[r].typed && it.last;
                it.want  = DIR_TABLE[r].want;
                stim_q.push_back(it);
            end
        end

        rand_count = 0;
        mid_hold   = 1'b0;
        while (rand_count < RAND_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 3)       n = 1;
            else if (pick < 16) n = $urandom_range(2, 12);
            else if (pick < 19) n = $urandom_range(13, 64);
            else                n = $urandom_range(65, 300);
            mode     = $urandom_range(0, 3);
            base     = SMP_W'($urandom_range(0, 65535));
            set_hold = (rand_count == 0) || (!mid_hold && rand_count >= RAND_ITEMS / 2);
            if (rand_count >= RAND_ITEMS / 2) mid_hold = 1'b1;
            for (int k = 0; k < n; k++) begin
                case (mode)
                    0:       v = SMP_W'($urandom_range(0, 65535));
                    1:       v = SMP_W'(base + $urandom_range(0, 63) - 32);
                    2:       v = EXTREMES[$urandom_range(0, 4)];
                    default: v = SMP_W'($urandom_range(0, 511) - 256);
                endcase
                it.smp   = v;
                it.last  = (k == n - 1);
                it.hold  = set_hold && (k == 0);
                it.typed = 1'b0;
                it.want  = NO_STATS;
                stim_q.push_back(it);
            end
            rand_count += n;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_q[i]) begin
            gap = draw_gap(tx_burst);
            if (stim_q[i].hold) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_stats_q.size() != 0);
            end else if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[i].smp;
            s_tlast  <= stim_q[i].last;
            do @(posedge aclk); while (!s_tready);
            if (absorb_sample(stim_q[i].smp, stim_q[i].last, res))
                pending_stats_q.push_back(stim_q[i].typed ? stim_q[i].want : res);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_stats_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += pending_stats_q.size();

        $display("Run covered %0d data sets over %0d samples in %0d cycles",
                 sets_seen, samples_seen, cycle_count);
        $display("  %0d sets under two samples, %0d sets past buffer depth, %0d mismatches",
                 short_sets, overflow_sets, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tpmsv_pkg.sv
rtl/tpmsv_ram.sv
rtl/tpmsv_divider.sv
rtl/tpmsv_sqacc.sv
rtl/two_pass_mean_sample_variance_unit.sv
rtl/tpmsv_checker.sv
dv/tb_two_pass_mean_sample_variance_unit.sv
